// ===== rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, command and status codes, and field widths for the
// indexed stack list.
// ----------------------------------------------------------------------------
package isl_pkg;

  // Fixed field widths of the item ports.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 4;
  localparam int REC_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_PAST  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Operation decoded from one item, handed from the decoder to the store
  // and the result register.
  typedef struct packed {
    logic              ins;     // insert at index, shift lower entries down
    logic              rem;     // remove at index, shift lower entries up
    logic              clr;     // empty the stack
    logic              rd;      // item returns the entry at index
    logic [STAT_W-1:0] status;
  } isl_op_t;

endpackage

// ===== rtl/indexed_stack_list.sv =====
// ----------------------------------------------------------------------------
// indexed_stack_list
// Stack of records with insert, take and read at an index counted from the
// top, plus clear. One result item for every input item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | command, position, record_in
//  out_    | output    | out_valid / out_stall  | record_out, status, count_now
//
// An item is held in the input register, then decoded and applied to the
// register array as it advances, which also loads the result register.
// One item per cycle is sustained while the result is not stalled.
// Reset clears the fill count and both valid flags; records are not cleared.
// A stalled result holds the input register, which then stalls the input.
// ----------------------------------------------------------------------------
module indexed_stack_list #(
  parameter int DEPTH      = isl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = isl_pkg::DATA_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [isl_pkg::CMD_W-1:0]    in_command,
  input  logic [isl_pkg::POS_W-1:0]    in_position,
  input  logic [isl_pkg::REC_W-1:0]    in_record_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [isl_pkg::REC_W-1:0]    out_record_out,
  output logic [isl_pkg::STAT_W-1:0]   out_status,
  output logic [isl_pkg::CNT_OUT_W-1:0] out_count_now
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic                          in_vld_r;
  logic [isl_pkg::CMD_W-1:0]     cmd_r;
  logic [isl_pkg::POS_W-1:0]     pos_r;
  logic [DATA_WIDTH-1:0]         rec_r;

  logic                          out_vld_r;
  logic [isl_pkg::REC_W-1:0]     rec_out_r;
  logic [isl_pkg::STAT_W-1:0]    stat_r;
  logic [isl_pkg::CNT_OUT_W-1:0] cnt_out_r;

  isl_pkg::isl_op_t              op;
  logic [IW-1:0]                 idx;
  logic [DATA_WIDTH-1:0]         rd_data;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 cnt_nxt;
  logic                          advance;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  assign out_valid      = out_vld_r;
  assign out_record_out = rec_out_r;
  assign out_status     = stat_r;
  assign out_count_now  = cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      rec_r <= DATA_WIDTH'(in_record_in);
    end
  end

  isl_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .command  (cmd_r),
    .position (pos_r),
    .count    (count),
    .op       (op),
    .idx      (idx)
  );

  isl_store #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .op      (op),
    .idx     (idx),
    .wr_data (rec_r),
    .rd_data (rd_data),
    .count   (count),
    .cnt_nxt (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rec_out_r <= op.rd ? isl_pkg::REC_W'(rd_data) : '0;
      stat_r    <= op.status;
      cnt_out_r <= isl_pkg::CNT_OUT_W'(cnt_nxt);
    end
  end

endmodule

// ===== rtl/isl_decode.sv =====
// ----------------------------------------------------------------------------
// isl_decode
// Turns a command, a position and the current fill count into an operation,
// an effective index and a status code.
// ----------------------------------------------------------------------------
module isl_decode #(
  parameter int DEPTH = isl_pkg::DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic [isl_pkg::CMD_W-1:0] command,
  input  logic [isl_pkg::POS_W-1:0] position,
  input  logic [CW-1:0]             count,
  output isl_pkg::isl_op_t          op,
  output logic [IW-1:0]             idx
);

  // Compare width wide enough for both the position and the count.
  localparam int CMPW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] idx_x;
  logic            full;
  logic            empty;

  assign pos_x = CMPW'(position);
  assign cnt_x = CMPW'(count);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign idx   = idx_x[IW-1:0];

  always_comb begin
    op        = '0;
    op.status = isl_pkg::ST_OK;
    idx_x     = pos_x;
    unique case (command)
      isl_pkg::CMD_INSERT: begin
        if (full) begin
          op.status = isl_pkg::ST_FULL;
        end else begin
          op.ins = 1'b1;
          // A position beyond the count lands at the bottom.
          if (pos_x > cnt_x) begin
            idx_x     = cnt_x;
            op.status = isl_pkg::ST_PAST;
          end
        end
      end
      isl_pkg::CMD_TAKE, isl_pkg::CMD_READ: begin
        if (empty) begin
          op.status = isl_pkg::ST_EMPTY;
        end else begin
          op.rd  = 1'b1;
          op.rem = (command == isl_pkg::CMD_TAKE);
          if (pos_x >= cnt_x) begin
            idx_x     = cnt_x - CMPW'(1);
            op.status = isl_pkg::ST_PAST;
          end
        end
      end
      isl_pkg::CMD_CLEAR: begin
        op.clr = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
  end

endmodule

// ===== rtl/isl_store.sv =====
// ----------------------------------------------------------------------------
// isl_store
// Register array of records with the fill count. Every entry can take its
// upper or lower neighbor, so an insert or a removal at any index shifts
// all affected entries in a single update.
// ----------------------------------------------------------------------------
module isl_store #(
  parameter int DEPTH  = isl_pkg::DEPTH_DEF,
  parameter int DATA_W = isl_pkg::DATA_W_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int IW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  isl_pkg::isl_op_t op,
  input  logic [IW-1:0]    idx,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data,
  output logic [CW-1:0]    count,
  output logic [CW-1:0]    cnt_nxt
);

  logic [DATA_W-1:0] ent_r [DEPTH];
  logic [CW-1:0]     cnt_r;

  assign count   = cnt_r;
  assign rd_data = ent_r[idx];

  always_comb begin
    priority if (op.clr) begin
      cnt_nxt = '0;
    end else if (op.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (op.rem) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    // Neighbor sources; the first entry points at itself, where the shift can
    // never select it, and the last entry keeps its own value on a removal.
    localparam int LO = (g == 0) ? 0 : g - 1;
    localparam int HI = (g == DEPTH - 1) ? g : g + 1;

    always_ff @(posedge clk) begin
      if (en) begin
        if (op.ins && (idx == IW'(g))) begin
          ent_r[g] <= wr_data;
        end else if (op.ins && (idx < IW'(g))) begin
          ent_r[g] <= ent_r[LO];
        end else if (op.rem && (idx <= IW'(g))) begin
          ent_r[g] <= ent_r[HI];
        end
      end
    end
  end

endmodule
